>>> hw/rtl/olst_pkg.sv
// Shared types, constants and helpers for the ordered list store.
// Used by olst_cell and ordered_list_store; depends on nothing else.
package olst_pkg;

	// list geometry
	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int IDX_W      = $clog2(CAPACITY);
	// compare width for positions and counts (holds count and position up to 255)
	localparam int POS_W      = 8;

	// stream payload widths
	localparam int IN_W  = 40;
	localparam int OUT_W = 40;

	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_END   = 3'd1,
		OP_INS_AT    = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_END   = 3'd4,
		OP_DEL_AT    = 3'd5,
		OP_LIST      = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_ROT
	} cell_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_LIST
	} state_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t          kind;
		logic [POS_W-1:0]  pos;
		word_t             word;
		word_t             head;
	} cell_ctrl_t;

	// sign-extend the 32-bit input word, keep DATA_WIDTH bits
	function automatic word_t to_word(input logic signed [31:0] v);
		logic signed [63:0] ext;
		ext = 64'(v);
		return ext[DATA_WIDTH-1:0];
	endfunction

	// low 32 bits of a stored word, zero-extended when narrower
	function automatic logic [31:0] from_word(input word_t w);
		logic [63:0] z;
		z = 64'(w);
		return z[31:0];
	endfunction

endpackage

>>> hw/rtl/olst_cell.sv
// One storage cell of the list chain: holds one entry, shifts from a neighbor.
// Depends on olst_pkg for the control struct and word type.
module olst_cell import olst_pkg::*; (
	input  logic             clk,
	input  logic [IDX_W-1:0] idx,
	input  cell_ctrl_t       ctrl,
	input  word_t            left_data,
	input  word_t            right_data,
	output word_t            data
);

	word_t            data_q;
	word_t            data_d;
	logic [POS_W-1:0] idx_w;

	assign idx_w = POS_W'(idx);

	// next entry: shift up on insert, down on delete, rotate while listing
	always_comb begin
		data_d = data_q;
		case (ctrl.kind)
			CELL_INS: begin
				if (idx_w > ctrl.pos) begin
					data_d = left_data;
				end else if (idx_w == ctrl.pos) begin
					data_d = ctrl.word;
				end
			end
			CELL_DEL: begin
				if (idx_w >= ctrl.pos) begin
					data_d = right_data;
				end
			end
			CELL_ROT: begin
				if (idx_w < ctrl.pos) begin
					data_d = right_data;
				end else if (idx_w == ctrl.pos) begin
					data_d = ctrl.head;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

>>> hw/rtl/ordered_list_store.sv
// Ordered list store: top level with control, result register and cell chain.
// Depends on olst_pkg and olst_cell.
// Insert and delete: one item per cycle unless the output stalls; the status is
// registered and appears in the cycle after accept. Listing: one entry per cycle
// from the head cell unless the output stalls; the chain rotates once and ends in
// its original order. No new item is taken while listing. Reset (arst_n low,
// asynchronous) empties the list and the result register, not the cell contents.
module ordered_list_store import olst_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [IN_W-1:0] s_tdata,   // op[2:0], position[7:3], value[39:8]
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [OUT_W-1:0] m_tdata,  // status[1:0], entry_position[5:2],
	                                   // entry_value[37:6], zero[39:38]
	output logic            m_tlast
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] list_idx_q;
	logic             m_tvalid_q;
	status_t          out_status_q;
	logic [3:0]       out_pos_q;
	logic [31:0]      out_value_q;
	logic             out_last_q;

	op_t              op;
	logic [4:0]       pos_in;
	logic [31:0]      value_in;
	logic [POS_W-1:0] cnt_w, pos_w, eff_pos;
	logic             is_ins, is_del, is_list;
	status_t          status;
	logic             slot_free, accept, list_step, list_last, out_load;
	logic [63:0]      list_pos64;
	cell_ctrl_t       cell_ctrl;
	word_t            cell_data [CAPACITY];

	assign op       = op_t'(s_tdata[2:0]);
	assign pos_in   = s_tdata[7:3];
	assign value_in = s_tdata[39:8];
	assign cnt_w    = POS_W'(count_q);
	assign pos_w    = POS_W'(pos_in);

	assign slot_free  = !m_tvalid_q || m_tready;
	assign accept     = s_tvalid && s_tready;
	assign list_last  = (list_idx_q == CNT_W'(count_q - 1'b1));
	assign list_pos64 = 64'(list_idx_q);

	// decode the op and work out its status
	always_comb begin
		is_ins  = 1'b0;
		is_del  = 1'b0;
		is_list = 1'b0;
		eff_pos = '0;
		case (op)
			OP_INS_FRONT: begin
				is_ins = 1'b1;
			end
			OP_INS_END: begin
				is_ins  = 1'b1;
				eff_pos = cnt_w;
			end
			OP_INS_AT: begin
				is_ins  = 1'b1;
				eff_pos = pos_w;
			end
			OP_DEL_FRONT: begin
				is_del = 1'b1;
			end
			OP_DEL_END: begin
				is_del  = 1'b1;
				eff_pos = cnt_w - 1'b1;
			end
			OP_DEL_AT: begin
				is_del  = 1'b1;
				eff_pos = pos_w;
			end
			OP_LIST: begin
				is_list = 1'b1;
			end
			default: begin
				is_ins = 1'b0;
			end
		endcase

		status = STAT_OK;
		if (is_ins) begin
			if (count_q >= CNT_W'(CAPACITY)) begin
				status = STAT_FULL;
			end else if (eff_pos > cnt_w) begin
				status = STAT_RANGE;
			end
		end else if (is_del || is_list) begin
			if (count_q == '0) begin
				status = STAT_EMPTY;
			end else if (is_del && eff_pos >= cnt_w) begin
				status = STAT_RANGE;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_list && count_q != '0) begin
					state_d = ST_LIST;
				end
			end
			ST_LIST: begin
				if (slot_free && list_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the controller
	always_comb begin
		s_tready       = 1'b0;
		list_step      = 1'b0;
		cell_ctrl.kind = CELL_HOLD;
		cell_ctrl.pos  = eff_pos;
		cell_ctrl.word = to_word(value_in);
		cell_ctrl.head = cell_data[0];
		case (state_q)
			ST_IDLE: begin
				s_tready = slot_free;
				if (accept && status == STAT_OK) begin
					if (is_ins) begin
						cell_ctrl.kind = CELL_INS;
					end else if (is_del) begin
						cell_ctrl.kind = CELL_DEL;
					end
				end
			end
			ST_LIST: begin
				list_step = slot_free;
				cell_ctrl.pos = cnt_w - 1'b1;
				if (slot_free) begin
					cell_ctrl.kind = CELL_ROT;
				end
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign out_load = list_step ||
		(accept && (is_ins || is_del || (is_list && count_q == '0)));

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			list_idx_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cell_ctrl.kind == CELL_INS) begin
				count_q <= count_q + 1'b1;
			end else if (cell_ctrl.kind == CELL_DEL) begin
				count_q <= count_q - 1'b1;
			end
			if (state_q == ST_IDLE) begin
				list_idx_q <= '0;
			end else if (list_step) begin
				list_idx_q <= list_idx_q + 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result register: listed entry or status item
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (list_step) begin
				out_status_q <= STAT_OK;
				out_pos_q    <= list_pos64[3:0];
				out_value_q  <= from_word(cell_data[0]);
				out_last_q   <= list_last;
			end else begin
				out_status_q <= status;
				out_pos_q    <= '0;
				out_value_q  <= '0;
				out_last_q   <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_value_q, out_pos_q, out_status_q};
	assign m_tlast  = out_last_q;

	// chain of cells, each fed by its neighbors
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t left_w, right_w;
		if (i == 0) begin : g_head
			assign left_w = cell_ctrl.word;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		olst_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(i)),
			.ctrl       (cell_ctrl),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[i])
		);
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("list count above capacity");

	a_list_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LIST |-> list_idx_q < count_q)
		else $error("listing index past the end");

	a_no_accept_list: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LIST |-> !s_tready)
		else $error("input taken while listing");

	a_list_done: assert property (@(posedge clk) disable iff (!arst_n)
		(list_step && list_last) |=> (state_q == ST_IDLE && m_tvalid && m_tlast))
		else $error("listing did not end on its last item");

endmodule

>>> tb/sv/tb_ordered_list_store.sv
// Self-checking testbench for ordered_list_store: directed table, then random traffic.
// Depends on olst_pkg and the ordered_list_store RTL; predicts results with its own list model.
`timescale 1ns / 100ps

module tb_ordered_list_store;
	import olst_pkg::*;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS = 70;

	// one result item as it leaves the block
	typedef struct packed {
		status_t     status;
		logic [3:0]  epos;
		logic [31:0] evalue;
		logic        last;
	} olst_result_t;

	// one row of the directed table; reps > 1 walks value upward
	typedef struct packed {
		logic [2:0]  op;
		logic [4:0]  pos;
		logic [31:0] value;
		int          reps;
		bit          has_status;
		status_t     status;
	} row_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [IN_W-1:0] s_tdata = '0;   // op[2:0], position[7:3], value[39:8]
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;       // status[1:0], entry_position[5:2], entry_value[37:6]
	logic            m_tlast;

	// list contents as the predictor sees them, front first
	word_t        list_words[$];
	olst_result_t fresh_results[$];
	olst_result_t due_results[$];

	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int quiet_cycles = 0;
	olst_result_t seen, want;

	// directed stimulus: empty-list cases, extremes, append by position, fill to full
	row_t directed_rows [0:24] = '{
		'{OP_LIST,      5'd0,  32'h0000_0000, 1,  1'b1, STAT_EMPTY},
		'{OP_DEL_FRONT, 5'd0,  32'h0000_0000, 1,  1'b1, STAT_EMPTY},
		'{OP_DEL_END,   5'd0,  32'h0000_0000, 1,  1'b1, STAT_EMPTY},
		'{OP_DEL_AT,    5'd31, 32'h0000_0000, 1,  1'b1, STAT_EMPTY},
		'{OP_INS_AT,    5'd1,  32'h0000_0005, 1,  1'b1, STAT_RANGE},
		'{OP_INS_FRONT, 5'd0,  32'h8000_0000, 1,  1'b1, STAT_OK},
		'{OP_INS_END,   5'd0,  32'h7fff_ffff, 1,  1'b1, STAT_OK},
		'{OP_INS_AT,    5'd1,  32'hffff_ffff, 1,  1'b1, STAT_OK},
		'{OP_INS_AT,    5'd3,  32'h0000_0000, 1,  1'b1, STAT_OK},
		'{OP_INS_AT,    5'd31, 32'h0000_1234, 1,  1'b1, STAT_RANGE},
		'{OP_LIST,      5'd0,  32'h0000_0000, 1,  1'b0, STAT_OK},
		'{OP_DEL_AT,    5'd4,  32'h0000_0000, 1,  1'b1, STAT_RANGE},
		'{OP_DEL_AT,    5'd1,  32'h0000_0000, 1,  1'b1, STAT_OK},
		'{OP_UNUSED,    5'd31, 32'hffff_ffff, 1,  1'b0, STAT_OK},
		'{OP_DEL_FRONT, 5'd0,  32'h0000_0000, 1,  1'b1, STAT_OK},
		'{OP_DEL_END,   5'd0,  32'h0000_0000, 1,  1'b1, STAT_OK},
		'{OP_DEL_AT,    5'd0,  32'h0000_0000, 1,  1'b1, STAT_OK},
		'{OP_LIST,      5'd0,  32'h0000_0000, 1,  1'b1, STAT_EMPTY},
		'{OP_INS_END,   5'd0,  32'h5555_aaaa, 16, 1'b1, STAT_OK},
		'{OP_INS_FRONT, 5'd0,  32'h0bad_f00d, 1,  1'b1, STAT_FULL},
		'{OP_INS_AT,    5'd31, 32'h0bad_f00d, 1,  1'b1, STAT_FULL},
		'{OP_INS_AT,    5'd16, 32'h0bad_f00d, 1,  1'b1, STAT_FULL},
		'{OP_LIST,      5'd0,  32'h0000_0000, 1,  1'b0, STAT_OK},
		'{OP_DEL_AT,    5'd16, 32'h0000_0000, 1,  1'b1, STAT_RANGE},
		'{OP_DEL_AT,    5'd15, 32'h0000_0000, 1,  1'b1, STAT_OK}
	};

	ordered_list_store u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		errors++;
		$display("mismatch @%0t: %s", $time, what);
	endtask

	function automatic status_t insert_word(input int at, input word_t w);
		if (list_words.size() >= CAPACITY)
			return STAT_FULL;
		if (at > list_words.size())
			return STAT_RANGE;
		list_words.insert(at, w);
		return STAT_OK;
	endfunction

	function automatic status_t delete_word(input int at);
		if (list_words.size() == 0)
			return STAT_EMPTY;
		if (at >= list_words.size())
			return STAT_RANGE;
		list_words.delete(at);
		return STAT_OK;
	endfunction

	// applies one accepted item to the list and leaves its results in fresh_results
	function automatic void apply_list_op(input logic [2:0] op, input logic [4:0] pos,
	                                      input logic [31:0] value);
		word_t        w;
		int           n;
		status_t      st;
		olst_result_t r;
		w = word_t'($signed(value));
		n = list_words.size();
		fresh_results.delete();
		st = STAT_OK;
		case (op)
			OP_INS_FRONT: st = insert_word(0, w);
			OP_INS_END:   st = insert_word(n, w);
			OP_INS_AT:    st = insert_word(int'(pos), w);
			OP_DEL_FRONT: st = delete_word(0);
			OP_DEL_END:   st = (n == 0) ? STAT_EMPTY : delete_word(n - 1);
			OP_DEL_AT:    st = delete_word(int'(pos));
			OP_LIST: begin
				if (n == 0) begin
					st = STAT_EMPTY;
				end else begin
					for (int i = 0; i < n; i++) begin
						r.status = STAT_OK;
						r.epos   = 4'(i);
						r.evalue = 32'(list_words[i]);
						r.last   = (i == n - 1);
						fresh_results.push_back(r);
					end
					return;
				end
			end
			default: return;   // unused code: no result, no change
		endcase
		r.status = st;
		r.epos   = '0;
		r.evalue = '0;
		r.last   = 1'b1;
		fresh_results.push_back(r);
	endfunction

	// offers one item, waits for it to be taken, then records what it should produce
	task automatic offer_item(input logic [2:0] op, input logic [4:0] pos,
	                          input logic [31:0] value, input bit has_status,
	                          input status_t status);
		olst_result_t typed_res;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {value, pos, op};
		do @(posedge clk); while (!s_tready);
		apply_list_op(op, pos, value);
		if (has_status) begin
			typed_res.status = status;
			typed_res.epos   = '0;
			typed_res.evalue = '0;
			typed_res.last   = 1'b1;
			due_results.push_back(typed_res);
		end else begin
			foreach (fresh_results[i])
				due_results.push_back(fresh_results[i]);
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin : receiver
		int hold_seen;
		hold_seen = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen.status = status_t'(m_tdata[1:0]);
			seen.epos   = m_tdata[5:2];
			seen.evalue = m_tdata[37:6];
			seen.last   = m_tlast;
			if (m_tdata[39:38] != 2'b00)
				report_mismatch($sformatf("pad bits %b", m_tdata[39:38]));
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h last %b", m_tdata, m_tlast));
			end else begin
				want = due_results.pop_front();
				if (seen.status != want.status)
					report_mismatch($sformatf("status %0d, want %0d", seen.status, want.status));
				if (seen.epos != want.epos)
					report_mismatch($sformatf("position %0d, want %0d", seen.epos, want.epos));
				if (seen.evalue != want.evalue)
					report_mismatch($sformatf("value %h, want %h", seen.evalue, want.evalue));
				if (seen.last != want.last)
					report_mismatch($sformatf("last %b, want %b", seen.last, want.last));
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// stimulus
	initial begin : stimulus
		int          ph, k, n, pick, ins_pct;
		logic [2:0]  op;
		logic [4:0]  pos;
		logic [31:0] val;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			for (k = 0; k < directed_rows[i].reps; k++)
				offer_item(directed_rows[i].op, directed_rows[i].pos,
				           32'(directed_rows[i].value + k), directed_rows[i].has_status,
				           directed_rows[i].status);

		// random phases; fill-leaning and drain-leaning stretches alternate
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
					hold_req++;
				end
				1: begin
					idle_pct  = 48;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 48;
				end
				default: begin
					idle_pct  = 11;
					stall_pct = 11;
				end
			endcase
			for (k = 0; k < PHASE_ITEMS; k++) begin
				ins_pct = ((k / 20) % 2 == 0) ? 70 : 28;
				n = list_words.size();
				pick = $urandom_range(0, 99);
				if (pick < ins_pct) begin
					case ($urandom_range(0, 2))
						0:       op = OP_INS_FRONT;
						1:       op = OP_INS_END;
						default: op = OP_INS_AT;
					endcase
				end else if (pick < ins_pct + 4) begin
					op = OP_LIST;
				end else if (pick < ins_pct + 6) begin
					op = OP_UNUSED;
				end else begin
					case ($urandom_range(0, 2))
						0:       op = OP_DEL_FRONT;
						1:       op = OP_DEL_END;
						default: op = OP_DEL_AT;
					endcase
				end
				pos = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
				                                  : 5'($urandom_range(0, n));
				case ($urandom_range(0, 9))
					0:       val = 32'h8000_0000;
					1:       val = 32'h7fff_ffff;
					2:       val = '1;
					3:       val = '0;
					default: val = $urandom;
				endcase
				offer_item(op, pos, val, 1'b0, STAT_OK);
			end
		end
		s_tvalid <= 1'b0;

		// drain: watchdog covers a hang here
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
